// File: sv/fpst_pkg.sv
// Shared types, codes and constants of the flash page state tracker.
`default_nettype none

package fpst_pkg;

   // default sizing of the tracked array
   localparam int MAX_BLOCKS_DEFAULT = 256;
   localparam int MAX_PAGES_DEFAULT  = 64;

   // command kinds
   localparam logic [1:0] KIND_PROGRAM    = 2'd0;
   localparam logic [1:0] KIND_INVALIDATE = 2'd1;
   localparam logic [1:0] KIND_ERASE      = 2'd2;
   localparam logic [1:0] KIND_READ       = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_RANGE    = 2'd1;
   localparam logic [1:0] STAT_NOT_FREE = 2'd2;

   // page marks
   localparam logic [1:0] MARK_FREE    = 2'd0;
   localparam logic [1:0] MARK_VALID   = 2'd1;
   localparam logic [1:0] MARK_INVALID = 2'd2;

   // register indexes (word address bit 2)
   localparam logic CSR_BLOCKS = 1'b0;
   localparam logic CSR_PAGES  = 1'b1;

   localparam logic [31:0] UNMAPPED_LPN = 32'hFFFF_FFFF;
   localparam logic [6:0]  COUNT_TOP    = 7'd127;
   localparam logic [8:0]  BLOCKS_RESET = 9'd256;
   localparam logic [6:0]  PAGES_RESET  = 7'd64;

   typedef struct packed {
      logic [1:0]  mark;
      logic [31:0] owner;
   } page_entry_type;

   typedef struct packed {
      logic [31:0] erases;
      logic [6:0]  free_cnt;
      logic [6:0]  valid_cnt;
      logic [6:0]  invalid_cnt;
   } block_entry_type;

endpackage

`default_nettype wire

// File: sv/fpst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fpst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                      clock,
   input  wire                                      wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                          wr_data,
   input  wire                                      rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/flash_page_state_tracker_core.sv
// Flash page and block state tracker: page table, block counters and APB registers.
// A result strobes from the read-modify-write state, or straight from idle when an
// out-of-range word is accepted. Program, invalidate and read each make one read-modify-write;
// erase makes one too and then sweeps the pages of its block, one page entry written per cycle.
// Reset: a clearing pass writes all MAX_BLOCKS * 2**clog2(MAX_PAGES) page entries, one per
// cycle, and the block counters with them; busy stays high until it ends.
`default_nettype none

module flash_page_state_tracker_core #(
   parameter int MAX_BLOCKS = fpst_pkg::MAX_BLOCKS_DEFAULT,
   parameter int MAX_PAGES  = fpst_pkg::MAX_PAGES_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // command channel
   input  wire         start,
   output logic        busy,
   input  wire [1:0]   req_kind,
   input  wire [7:0]   req_block_index,
   input  wire [5:0]   req_page_index,
   input  wire [31:0]  req_logical_page,
   // result channel
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_page_state,
   output logic [31:0] rsp_page_logical,
   output logic [31:0] rsp_erase_total,
   output logic [6:0]  rsp_free_count,
   output logic [6:0]  rsp_valid_count,
   output logic [6:0]  rsp_invalid_count,
   // register port
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire [2:0]   paddr,
   input  wire [31:0]  pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int BAW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int PW         = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int AW         = BAW + PW;
   localparam int PAGE_DEPTH = MAX_BLOCKS * (2 ** PW);
   localparam logic [AW-1:0] LAST_ADDR = AW'(PAGE_DEPTH - 1);
   localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_PAGES - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_ERASE = 2'd3;

   function automatic logic [6:0] count_up(input logic [6:0] c);
      return (c < fpst_pkg::COUNT_TOP) ? c + 7'd1 : c;
   endfunction

   function automatic logic [6:0] count_down(input logic [6:0] c);
      return (c != 7'd0) ? c - 7'd1 : c;
   endfunction

   // registers
   logic [8:0] blocks_ff;
   logic [6:0] pages_ff;

   // control
   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;

   // held command word
   logic [1:0]     kind_ff;
   logic [BAW-1:0] blk_ff;
   logic [PW-1:0]  pg_ff;
   logic [31:0]    lpn_ff;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [1:0]  rsp_page_state_ff, rsp_page_state_in;
   logic [31:0] rsp_page_logical_ff, rsp_page_logical_in;
   logic [31:0] rsp_erase_total_ff, rsp_erase_total_in;
   logic [6:0]  rsp_free_count_ff, rsp_free_count_in;
   logic [6:0]  rsp_valid_count_ff, rsp_valid_count_in;
   logic [6:0]  rsp_invalid_count_ff, rsp_invalid_count_in;

   // memory ports
   fpst_pkg::page_entry_type  page_rd, page_new, page_wdata;
   fpst_pkg::block_entry_type block_rd, block_new, block_wdata, block_clear;
   logic           page_we, block_we, page_mod, accept, in_range, blk_ok, pg_ok;
   logic [AW-1:0]  page_waddr, page_raddr;
   logic [BAW-1:0] block_waddr, block_raddr;
   logic [1:0]     stat_mod;
   logic [6:0]     page_limit;
   logic           csr_wr;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= fpst_pkg::BLOCKS_RESET;
         pages_ff  <= fpst_pkg::PAGES_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            fpst_pkg::CSR_BLOCKS: blocks_ff <= pwdata[8:0];
            fpst_pkg::CSR_PAGES:  pages_ff  <= pwdata[6:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         fpst_pkg::CSR_BLOCKS: prdata = {23'd0, blocks_ff};
         fpst_pkg::CSR_PAGES:  prdata = {25'd0, pages_ff};
      endcase
   end

   // range check of the incoming word
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign blk_ok = (32'(req_block_index) < 32'(blocks_ff))
                && (32'(req_block_index) < 32'(MAX_BLOCKS));
   assign pg_ok  = (req_kind == fpst_pkg::KIND_ERASE)
                || ((32'(req_page_index) < 32'(pages_ff))
                    && (32'(req_page_index) < 32'(MAX_PAGES)));
   assign in_range = blk_ok && pg_ok;

   assign page_limit = (32'(pages_ff) < 32'(MAX_PAGES)) ? pages_ff : 7'(MAX_PAGES);

   assign page_raddr  = {BAW'(req_block_index), PW'(req_page_index)};
   assign block_raddr = BAW'(req_block_index);

   // state memories
   fpst_ram #(
      .WIDTH ($bits(fpst_pkg::page_entry_type)),
      .DEPTH (PAGE_DEPTH)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (page_waddr),
      .wr_data (page_wdata),
      .rd_en   (accept),
      .rd_addr (page_raddr),
      .rd_data (page_rd)
   );

   fpst_ram #(
      .WIDTH ($bits(fpst_pkg::block_entry_type)),
      .DEPTH (MAX_BLOCKS)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (block_we),
      .wr_addr (block_waddr),
      .wr_data (block_wdata),
      .rd_en   (accept),
      .rd_addr (block_raddr),
      .rd_data (block_rd)
   );

   // modify the entries read for the held word
   always_comb begin
      page_new  = page_rd;
      block_new = block_rd;
      stat_mod  = fpst_pkg::STAT_OK;
      page_mod  = 1'b0;
      unique case (kind_ff)
         fpst_pkg::KIND_PROGRAM: begin
            if (page_rd.mark != fpst_pkg::MARK_FREE) begin
               stat_mod = fpst_pkg::STAT_NOT_FREE;
            end else begin
               page_new.mark       = fpst_pkg::MARK_VALID;
               page_new.owner      = lpn_ff;
               block_new.free_cnt  = count_down(block_rd.free_cnt);
               block_new.valid_cnt = count_up(block_rd.valid_cnt);
               page_mod            = 1'b1;
            end
         end
         fpst_pkg::KIND_INVALIDATE: begin
            if (page_rd.mark == fpst_pkg::MARK_VALID) begin
               page_new.mark         = fpst_pkg::MARK_INVALID;
               block_new.valid_cnt   = count_down(block_rd.valid_cnt);
               block_new.invalid_cnt = count_up(block_rd.invalid_cnt);
               page_mod              = 1'b1;
            end
         end
         fpst_pkg::KIND_ERASE: begin
            block_new.erases      = (block_rd.erases != '1) ? block_rd.erases + 32'd1
                                                            : block_rd.erases;
            block_new.free_cnt    = page_limit;
            block_new.valid_cnt   = 7'd0;
            block_new.invalid_cnt = 7'd0;
            page_new.mark         = fpst_pkg::MARK_FREE;
            page_new.owner        = fpst_pkg::UNMAPPED_LPN;
         end
         fpst_pkg::KIND_READ: begin
         end
      endcase
   end

   // select memory writes: clearing pass, erase sweep or write-back
   always_comb begin
      block_clear.erases      = 32'd0;
      block_clear.free_cnt    = fpst_pkg::PAGES_RESET;
      block_clear.valid_cnt   = 7'd0;
      block_clear.invalid_cnt = 7'd0;

      page_wdata.mark  = fpst_pkg::MARK_FREE;
      page_wdata.owner = fpst_pkg::UNMAPPED_LPN;
      page_waddr       = sweep_ff;
      page_we          = 1'b0;
      block_wdata      = block_clear;
      block_waddr      = sweep_ff[AW-1:PW];
      block_we         = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            page_we  = 1'b1;
            block_we = 1'b1;
         end
         ST_ERASE: begin
            page_we = 1'b1;
         end
         ST_READ: begin
            page_we     = page_mod;
            page_waddr  = {blk_ff, pg_ff};
            page_wdata  = page_new;
            block_we    = (kind_ff != fpst_pkg::KIND_READ);
            block_waddr = blk_ff;
            block_wdata = block_new;
         end
         ST_IDLE: begin
         end
      endcase
   end

   // sequence: clear, accept, read-modify-write, erase sweep
   always_comb begin
      state_in             = state_ff;
      sweep_in             = sweep_ff;
      rsp_valid_in         = 1'b0;
      rsp_status_in        = rsp_status_ff;
      rsp_page_state_in    = rsp_page_state_ff;
      rsp_page_logical_in  = rsp_page_logical_ff;
      rsp_erase_total_in   = rsp_erase_total_ff;
      rsp_free_count_in    = rsp_free_count_ff;
      rsp_valid_count_in   = rsp_valid_count_ff;
      rsp_invalid_count_in = rsp_invalid_count_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (in_range) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_status_in        = fpst_pkg::STAT_RANGE;
                  rsp_page_state_in    = 2'd0;
                  rsp_page_logical_in  = 32'd0;
                  rsp_erase_total_in   = 32'd0;
                  rsp_free_count_in    = 7'd0;
                  rsp_valid_count_in   = 7'd0;
                  rsp_invalid_count_in = 7'd0;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in         = 1'b1;
            rsp_status_in        = stat_mod;
            rsp_page_state_in    = page_new.mark;
            rsp_page_logical_in  = page_new.owner;
            rsp_erase_total_in   = block_new.erases;
            rsp_free_count_in    = block_new.free_cnt;
            rsp_valid_count_in   = block_new.valid_cnt;
            rsp_invalid_count_in = block_new.invalid_cnt;
            if (kind_ff == fpst_pkg::KIND_ERASE) begin
               sweep_in = {blk_ff, PW'(0)};
               state_in = ST_ERASE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ERASE: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff[PW-1:0] == LAST_PAGE) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the command word and the result word
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         blk_ff  <= BAW'(req_block_index);
         pg_ff   <= PW'(req_page_index);
         lpn_ff  <= req_logical_page;
      end
      rsp_status_ff        <= rsp_status_in;
      rsp_page_state_ff    <= rsp_page_state_in;
      rsp_page_logical_ff  <= rsp_page_logical_in;
      rsp_erase_total_ff   <= rsp_erase_total_in;
      rsp_free_count_ff    <= rsp_free_count_in;
      rsp_valid_count_ff   <= rsp_valid_count_in;
      rsp_invalid_count_ff <= rsp_invalid_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_page_state    = rsp_page_state_ff;
   assign rsp_page_logical  = rsp_page_logical_ff;
   assign rsp_erase_total   = rsp_erase_total_ff;
   assign rsp_free_count    = rsp_free_count_ff;
   assign rsp_valid_count   = rsp_valid_count_ff;
   assign rsp_invalid_count = rsp_invalid_count_ff;

   // checks
   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid_ff)
      else $error("read-modify-write cycle gave no result");

   a_erase_stays_in_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERASE) |-> (sweep_ff[AW-1:PW] == blk_ff))
      else $error("erase sweep left its block");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   a_range_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == fpst_pkg::STAT_RANGE)) |->
      ((rsp_erase_total_ff == 32'd0) && (rsp_page_logical_ff == 32'd0)
       && (rsp_free_count_ff == 7'd0) && (rsp_page_state_ff == 2'd0)))
      else $error("out-of-range result carries data");

endmodule

`default_nettype wire

// File: tb/fpst_checker.sv
// Checker for the flash page state tracker: tracks page and block state, predicts and compares.
module fpst_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire         busy,
   input  wire [1:0]   req_kind,
   input  wire [7:0]   req_block_index,
   input  wire [5:0]   req_page_index,
   input  wire [31:0]  req_logical_page,
   input  wire         rsp_valid,
   input  wire [1:0]   rsp_status,
   input  wire [1:0]   rsp_page_state,
   input  wire [31:0]  rsp_page_logical,
   input  wire [31:0]  rsp_erase_total,
   input  wire [6:0]   rsp_free_count,
   input  wire [6:0]   rsp_valid_count,
   input  wire [6:0]   rsp_invalid_count,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire [2:0]   paddr,
   input  wire [31:0]  pwdata,
   input  wire         pready,
   output int          fail_count,
   output int          pending
);

   localparam int NUM_BLOCKS = fpst_pkg::MAX_BLOCKS_DEFAULT;
   localparam int NUM_PAGES  = fpst_pkg::MAX_PAGES_DEFAULT;
   localparam int NUM_SLOTS  = NUM_BLOCKS * NUM_PAGES;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  state;
      logic [31:0] logical;
      logic [31:0] erases;
      logic [6:0]  free_cnt;
      logic [6:0]  valid_cnt;
      logic [6:0]  invalid_cnt;
   } page_report_type;

   logic [1:0]      mark_table    [NUM_SLOTS];
   logic [31:0]     owner_table   [NUM_SLOTS];
   logic [31:0]     erase_table   [NUM_BLOCKS];
   logic [6:0]      free_table    [NUM_BLOCKS];
   logic [6:0]      valid_table   [NUM_BLOCKS];
   logic [6:0]      invalid_table [NUM_BLOCKS];
   logic [8:0]      blocks_reg;
   logic [6:0]      pages_reg;
   page_report_type report_queue [$];
   int              failures;
   int              result_index;

   function automatic logic [6:0] count_inc(input logic [6:0] c);
      return (c < fpst_pkg::COUNT_TOP) ? c + 7'd1 : fpst_pkg::COUNT_TOP;
   endfunction

   function automatic logic [6:0] count_dec(input logic [6:0] c);
      return (c > 7'd0) ? c - 7'd1 : 7'd0;
   endfunction

   // Apply one command to the tracked state and return the word it should produce.
   function automatic page_report_type apply_command(input logic [1:0] kind,
                                                     input logic [7:0] blk,
                                                     input logic [5:0] pg,
                                                     input logic [31:0] lpn);
      int              block_lim;
      int              page_lim;
      int              base;
      int              slot;
      page_report_type rep;
      block_lim = (blocks_reg < NUM_BLOCKS) ? int'(blocks_reg) : NUM_BLOCKS;
      page_lim  = (pages_reg < NUM_PAGES) ? int'(pages_reg) : NUM_PAGES;
      rep = '0;
      if (int'(blk) >= block_lim
          || (kind != fpst_pkg::KIND_ERASE && int'(pg) >= page_lim)) begin
         rep.status = fpst_pkg::STAT_RANGE;
         return rep;
      end
      base = int'(blk) * NUM_PAGES;
      slot = base + int'(pg);
      rep.status = fpst_pkg::STAT_OK;
      unique case (kind)
         fpst_pkg::KIND_ERASE: begin
            // wipe every page of the block, not just the ones in use
            for (int p = 0; p < NUM_PAGES; p++) begin
               mark_table[base + p]  = fpst_pkg::MARK_FREE;
               owner_table[base + p] = fpst_pkg::UNMAPPED_LPN;
            end
            if (erase_table[blk] != 32'hFFFF_FFFF)
               erase_table[blk] = erase_table[blk] + 32'd1;
            free_table[blk]    = 7'(page_lim);
            valid_table[blk]   = 7'd0;
            invalid_table[blk] = 7'd0;
         end
         fpst_pkg::KIND_PROGRAM: begin
            if (mark_table[slot] != fpst_pkg::MARK_FREE) begin
               rep.status = fpst_pkg::STAT_NOT_FREE;
            end else begin
               mark_table[slot]  = fpst_pkg::MARK_VALID;
               owner_table[slot] = lpn;
               free_table[blk]   = count_dec(free_table[blk]);
               valid_table[blk]  = count_inc(valid_table[blk]);
            end
         end
         fpst_pkg::KIND_INVALIDATE: begin
            if (mark_table[slot] == fpst_pkg::MARK_VALID) begin
               mark_table[slot]   = fpst_pkg::MARK_INVALID;
               valid_table[blk]   = count_dec(valid_table[blk]);
               invalid_table[blk] = count_inc(invalid_table[blk]);
            end
         end
         fpst_pkg::KIND_READ: ;
      endcase
      rep.state       = mark_table[slot];
      rep.logical     = owner_table[slot];
      rep.erases      = erase_table[blk];
      rep.free_cnt    = free_table[blk];
      rep.valid_cnt   = valid_table[blk];
      rep.invalid_cnt = invalid_table[blk];
      return rep;
   endfunction

   // Track commands, compare result words, follow register writes.
   always @(posedge clock) begin
      page_report_type want;
      page_report_type got;
      page_report_type next_word;
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            mark_table[s]  = fpst_pkg::MARK_FREE;
            owner_table[s] = fpst_pkg::UNMAPPED_LPN;
         end
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            erase_table[b]   = 32'd0;
            free_table[b]    = fpst_pkg::PAGES_RESET;
            valid_table[b]   = 7'd0;
            invalid_table[b] = 7'd0;
         end
         blocks_reg = fpst_pkg::BLOCKS_RESET;
         pages_reg  = fpst_pkg::PAGES_RESET;
         report_queue.delete();
         failures     = 0;
         result_index = 0;
         fail_count <= 0;
         pending    <= 0;
      end else begin
         // check the result word against the oldest prediction
         if (rsp_valid === 1'b1) begin
            got = {rsp_status, rsp_page_state, rsp_page_logical, rsp_erase_total,
                   rsp_free_count, rsp_valid_count, rsp_invalid_count};
            if (report_queue.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("result %0d: word with no command outstanding (status %0d)",
                           result_index, rsp_status);
            end else begin
               want = report_queue.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("result %0d mismatch: expected st=%0d pg=%0d lpn=%h",
                              result_index, want.status, want.state, want.logical);
                     $display("   er=%0d f/v/i=%0d/%0d/%0d", want.erases,
                              want.free_cnt, want.valid_cnt, want.invalid_cnt);
                     $display("result %0d mismatch: actual   st=%0d pg=%0d lpn=%h",
                              result_index, got.status, got.state, got.logical);
                     $display("   er=%0d f/v/i=%0d/%0d/%0d", got.erases,
                              got.free_cnt, got.valid_cnt, got.invalid_cnt);
                  end
               end
            end
            result_index++;
         end
         // predict the accepted command
         if (start === 1'b1 && busy === 1'b0) begin
            next_word = apply_command(req_kind, req_block_index,
                                      req_page_index, req_logical_page);
            report_queue.insert(report_queue.size(), next_word);
         end
         // follow register writes
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == fpst_pkg::CSR_PAGES)
               pages_reg = pwdata[6:0];
            else
               blocks_reg = pwdata[8:0];
         end
         fail_count <= failures;
         pending    <= report_queue.size();
      end
   end

endmodule

// File: tb/tb.sv
// Testbench top for the flash page state tracker: stimulus, register setup and verdict.
module tb;

   localparam int STALL_LIMIT = 50000;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic [1:0]  req_kind         = fpst_pkg::KIND_READ;
   logic [7:0]  req_block_index  = '0;
   logic [5:0]  req_page_index   = '0;
   logic [31:0] req_logical_page = '0;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [2:0]  paddr            = '0;
   logic [31:0] pwdata           = '0;

   wire         busy;
   wire         rsp_valid;
   wire [1:0]   rsp_status;
   wire [1:0]   rsp_page_state;
   wire [31:0]  rsp_page_logical;
   wire [31:0]  rsp_erase_total;
   wire [6:0]   rsp_free_count;
   wire [6:0]   rsp_valid_count;
   wire [6:0]   rsp_invalid_count;
   wire [31:0]  prdata;
   wire         pready;

   int fail_count;
   int pending;
   int stall_cycles = 0;
   int kind_count [4] = '{default: 0};
   int settings_seen  = 0;
   int blocks_now     = 256;
   int pages_now      = 64;
   bit quiet          = 1'b0;

   flash_page_state_tracker_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_block_index   (req_block_index),
      .req_page_index    (req_page_index),
      .req_logical_page  (req_logical_page),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_page_state    (rsp_page_state),
      .rsp_page_logical  (rsp_page_logical),
      .rsp_erase_total   (rsp_erase_total),
      .rsp_free_count    (rsp_free_count),
      .rsp_valid_count   (rsp_valid_count),
      .rsp_invalid_count (rsp_invalid_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   fpst_checker tracker_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_block_index   (req_block_index),
      .req_page_index    (req_page_index),
      .req_logical_page  (req_logical_page),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_page_state    (rsp_page_state),
      .rsp_page_logical  (rsp_page_logical),
      .rsp_erase_total   (rsp_erase_total),
      .rsp_free_count    (rsp_free_count),
      .rsp_valid_count   (rsp_valid_count),
      .rsp_invalid_count (rsp_invalid_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort when no command or result word moves for too long (covers the clearing pass).
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Present one command word and hold it until accepted, idling at random each cycle.
   task automatic send_command(input logic [1:0] kind, input logic [7:0] blk,
                               input logic [5:0] pg, input logic [31:0] lpn);
      req_kind         <= kind;
      req_block_index  <= blk;
      req_page_index   <= pg;
      req_logical_page <= lpn;
      do begin
         start <= (!quiet && $urandom_range(0, 99) < 24) ? 1'b0 : 1'b1;
         @(posedge clock);
      end while (start !== 1'b1 || busy !== 1'b0);
      kind_count[kind]++;
   endtask

   // Pick a command biased toward a few hot blocks and pages so pages cycle through states.
   task automatic random_command();
      int         roll;
      int         hot_blocks;
      int         hot_pages;
      logic [1:0] kind;
      logic [7:0] blk;
      logic [5:0] pg;
      roll = $urandom_range(0, 99);
      priority if (roll < 40)
         kind = fpst_pkg::KIND_PROGRAM;
      else if (roll < 65)
         kind = fpst_pkg::KIND_INVALIDATE;
      else if (roll < 80)
         kind = fpst_pkg::KIND_ERASE;
      else
         kind = fpst_pkg::KIND_READ;
      hot_blocks = (blocks_now < 6) ? blocks_now : 6;
      hot_pages  = (pages_now < 16) ? pages_now : 16;
      if (hot_blocks > 0 && $urandom_range(0, 99) < 75)
         blk = 8'($urandom_range(0, hot_blocks - 1));
      else
         blk = 8'($urandom_range(0, 255));
      if (hot_pages > 0 && $urandom_range(0, 99) < 80)
         pg = 6'($urandom_range(0, hot_pages - 1));
      else
         pg = 6'($urandom_range(0, 63));
      send_command(kind, blk, pg, $urandom());
   endtask

   // Drop start and wait until every result is in and any erase sweep has finished.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy !== 1'b0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Change both limits once the block is idle; unused upper data bits get noise.
   task automatic set_limits(input int blocks, input int pages);
      wait_idle();
      write_reg(fpst_pkg::CSR_BLOCKS, {23'($urandom()), 9'(blocks)});
      write_reg(fpst_pkg::CSR_PAGES, {25'($urandom()), 7'(pages)});
      blocks_now = (blocks < 256) ? blocks : 256;
      pages_now  = (pages < 64) ? pages : 64;
      settings_seen++;
   endtask

   task automatic random_phase(input int blocks, input int pages, input int count);
      set_limits(blocks, pages);
      for (int i = 0; i < count; i++)
         random_command();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fresh state, not-free program, invalidate of free/valid/invalid pages, erase
      set_limits(256, 64);
      send_command(fpst_pkg::KIND_READ,       8'd0,   6'd0,  32'h0000_0000);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd0,   6'd0,  32'h0000_0000);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd0,   6'd0,  32'hFFFF_FFFF);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd255, 6'd63, 32'hFFFF_FFFF);
      send_command(fpst_pkg::KIND_INVALIDATE, 8'd255, 6'd63, 32'h0000_0000);
      send_command(fpst_pkg::KIND_INVALIDATE, 8'd255, 6'd63, 32'h0000_0000);
      send_command(fpst_pkg::KIND_INVALIDATE, 8'd0,   6'd1,  32'h0000_0000);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd255, 6'd63, 32'h0000_0001);
      send_command(fpst_pkg::KIND_READ,       8'd255, 6'd63, 32'h0000_0000);
      send_command(fpst_pkg::KIND_ERASE,      8'd255, 6'd10, 32'h0000_0000);
      send_command(fpst_pkg::KIND_READ,       8'd255, 6'd63, 32'h0000_0000);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd0,   6'd1,  32'hA5A5_5A5A);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd0,   6'd2,  32'h5A5A_A5A5);
      send_command(fpst_pkg::KIND_INVALIDATE, 8'd0,   6'd2,  32'h0000_0000);
      send_command(fpst_pkg::KIND_ERASE,      8'd0,   6'd63, 32'h0000_0000);

      // smallest limits: out-of-range on each kind, erase ignores the page index
      set_limits(1, 1);
      send_command(fpst_pkg::KIND_READ,       8'd1,   6'd0,  32'h0000_0000);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd0,   6'd1,  32'h1234_5678);
      send_command(fpst_pkg::KIND_ERASE,      8'd1,   6'd0,  32'h0000_0000);
      send_command(fpst_pkg::KIND_ERASE,      8'd0,   6'd63, 32'h0000_0000);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd0,   6'd0,  32'h8765_4321);
      send_command(fpst_pkg::KIND_INVALIDATE, 8'd0,   6'd5,  32'h0000_0000);

      // widen again: the free count of block zero is already at its floor
      set_limits(256, 64);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd0,   6'd5,  32'hDEAD_BEEF);
      send_command(fpst_pkg::KIND_READ,       8'd0,   6'd0,  32'h0000_0000);

      // zero limits reject everything, oversized limits clamp to the array
      set_limits(0, 0);
      send_command(fpst_pkg::KIND_ERASE,      8'd0,   6'd0,  32'h0000_0000);
      send_command(fpst_pkg::KIND_READ,       8'd0,   6'd0,  32'h0000_0000);
      set_limits(511, 127);
      send_command(fpst_pkg::KIND_PROGRAM,    8'd255, 6'd63, 32'h0F0F_F0F0);

      // random traffic; hold start back-to-back through part of the first phase
      set_limits(256, 64);
      for (int i = 0; i < 200; i++) begin
         quiet = (i >= 40 && i < 130);
         random_command();
      end
      quiet = 1'b0;
      random_phase(3, 8, 120);
      random_phase(511, 127, 100);
      random_phase(1, 1, 50);
      random_phase(200, 40, 130);
      random_phase(256, 64, 100);

      // drain, then leave room for a trailing erase sweep
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (80) @(posedge clock);

      $display("Ran %0d program, %0d invalidate, %0d erase and %0d read commands",
               kind_count[fpst_pkg::KIND_PROGRAM], kind_count[fpst_pkg::KIND_INVALIDATE],
               kind_count[fpst_pkg::KIND_ERASE], kind_count[fpst_pkg::KIND_READ]);
      $display("over %0d block/page limit settings, including zero and oversized limits",
               settings_seen);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
